[rtl/core/tld_pkg.sv]
// Shared widths and codes for the tree LCA / distance engine.
`timescale 1ns / 1ps
package tld_pkg;

	localparam int unsigned NODE_FIELD_W = 10;
	localparam int unsigned DEPTH_W      = 10;
	localparam int unsigned DIST_W       = 11;
	localparam int unsigned ALU_W        = DIST_W + 1;
	localparam int unsigned FOLD_STEPS   = 8;

	localparam int unsigned DEF_NODE_COUNT = 1024;
	localparam int unsigned DEF_LEVELS     = 10;

	localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;

	localparam logic ACT_ATTACH = 1'b0;
	localparam logic ACT_QUERY  = 1'b1;

endpackage

[rtl/core/tld_ifs.sv]
// Request and response channel interfaces of the tree LCA / distance engine.
`timescale 1ns / 1ps
interface tld_req_if;
	import tld_pkg::*;

	logic                    valid;
	logic                    ready;
	logic                    action;
	logic [NODE_FIELD_W-1:0] node_a;
	logic [NODE_FIELD_W-1:0] node_b;

	modport source (output valid, action, node_a, node_b, input ready);
	modport sink   (input valid, action, node_a, node_b, output ready);
endinterface

interface tld_rsp_if;
	import tld_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [NODE_FIELD_W-1:0] common_ancestor;
	logic [DIST_W-1:0]       distance;

	modport source (output valid, common_ancestor, distance, input ready);
	modport sink   (input valid, common_ancestor, distance, output ready);
endinterface

[rtl/core/tree_lca_distance_engine.sv]
// Binary-lifting LCA and tree distance engine: depth store, ancestor table, sequencer.
//
//  channel | dir | payload                      | items
//  --------+-----+------------------------------+-----------------------------
//  req     | in  | action, node_a, node_b       | attach (no result) or query
//  rsp     | out | common_ancestor, distance    | one per query
//
// Attach: writes one ancestor level at a time over the single table write port; an attach
// of node 0 is accepted and ignored. Query: the lifting loops lift the deeper node, then
// jump both nodes up to their common ancestor; the distance follows from its depth.
// After reset a clearing pass over all NODE_COUNT * 2^ceil(log2(LEVELS)) table entries
// (16384 at default) holds req.ready low. A result waits in the output register while the
// next item is accepted; a query's final state stalls while an earlier result is unaccepted.
`timescale 1ns / 1ps
module tree_lca_distance_engine #(
	parameter int unsigned NODE_COUNT = tld_pkg::DEF_NODE_COUNT,
	parameter int unsigned LEVELS     = tld_pkg::DEF_LEVELS
) (
	input  logic       clk,
	input  logic       arst_n,
	tld_req_if.sink    req,
	tld_rsp_if.source  rsp
);
	import tld_pkg::*;

	localparam int unsigned NW        = $clog2(NODE_COUNT);
	localparam int unsigned LW        = $clog2(LEVELS);
	localparam int unsigned AW        = NW + LW;
	localparam int unsigned ANC_DEPTH = NODE_COUNT << LW;

	localparam logic [LW-1:0] LVL_TOP  = LW'(LEVELS - 1);
	localparam logic [AW-1:0] CLR_LAST = AW'(ANC_DEPTH - 1);

	typedef enum logic [16:0] {
		S_CLEAR     = 17'h00001,
		S_IDLE      = 17'h00002,
		S_AT_DEP    = 17'h00004,
		S_AT_RD     = 17'h00008,
		S_AT_WB     = 17'h00010,
		S_Q_DEP     = 17'h00020,
		S_Q_DIFF    = 17'h00040,
		S_LIFT      = 17'h00080,
		S_LIFT_WB   = 17'h00100,
		S_CHECK     = 17'h00200,
		S_JUMP      = 17'h00400,
		S_JUMP_WB   = 17'h00800,
		S_PARENT    = 17'h01000,
		S_PARENT_WB = 17'h02000,
		S_TOP_RD    = 17'h04000,
		S_TOP_WB    = 17'h08000,
		S_DIST      = 17'h10000
	} state_t;

	// node field reduced modulo NODE_COUNT by restoring compare-subtract steps
	function automatic logic [NODE_FIELD_W-1:0] fold_node(input logic [NODE_FIELD_W-1:0] f);
		logic [NODE_FIELD_W-1:0] r;
		r = f;
		for (int k = FOLD_STEPS - 1; k >= 0; k--) begin
			if ((NODE_COUNT << k) < (1 << NODE_FIELD_W)) begin
				if (int'(r) >= int'(NODE_COUNT << k))
					r = r - NODE_FIELD_W'(NODE_COUNT << k);
			end
		end
		return r;
	endfunction

	function automatic logic [NW-1:0] to_idx(input logic [NODE_FIELD_W-1:0] f);
		logic [NW+NODE_FIELD_W-1:0] w;
		w = {{NW{1'b0}}, fold_node(f)};
		return w[NW-1:0];
	endfunction

	function automatic logic [NODE_FIELD_W-1:0] to_field(input logic [NW-1:0] n);
		logic [NW+NODE_FIELD_W-1:0] w;
		w = {{NODE_FIELD_W{1'b0}}, n};
		return w[NODE_FIELD_W-1:0];
	endfunction

	function automatic logic [ALU_W-1:0] ext_depth(input logic [DEPTH_W-1:0] d);
		return {{(ALU_W - DEPTH_W){1'b0}}, d};
	endfunction

	// storage
	logic [NW-1:0]      anc_mem [ANC_DEPTH];
	logic [DEPTH_W-1:0] dep_mem [NODE_COUNT];

	logic               anc_we;
	logic [AW-1:0]      anc_waddr;
	logic [NW-1:0]      anc_wdata;
	logic [AW-1:0]      anc_raddr_a;
	logic [AW-1:0]      anc_raddr_b;
	logic [NW-1:0]      anc_rdata_a_q;
	logic [NW-1:0]      anc_rdata_b_q;
	logic               dep_we;
	logic [NW-1:0]      dep_waddr;
	logic [DEPTH_W-1:0] dep_wdata;
	logic [NW-1:0]      dep_raddr_a;
	logic [NW-1:0]      dep_raddr_b;
	logic [DEPTH_W-1:0] dep_rdata_a_q;
	logic [DEPTH_W-1:0] dep_rdata_b_q;

	// control
	state_t        state_q, state_d;
	logic [LW-1:0] lvl_q, lvl_d;
	logic [AW-1:0] clr_q;
	logic          rsp_valid_q;
	logic          rsp_load;

	// datapath
	logic [NW-1:0]           a_q;
	logic [NW-1:0]           b_q;
	logic [NW-1:0]           top_q;
	logic [DEPTH_W-1:0]      da_q;
	logic [DEPTH_W-1:0]      db_q;
	logic [DEPTH_W-1:0]      dt_q;
	logic [DEPTH_W-1:0]      diff_q;
	logic [DIST_W-1:0]       sum_q;
	logic [NODE_FIELD_W-1:0] rsp_anc_q;
	logic [DIST_W-1:0]       rsp_dist_q;

	// shared add/subtract unit
	logic [ALU_W-1:0] alu_x, alu_y, alu_res;
	logic             alu_sub;
	logic             alu_neg;

	logic [NW-1:0]      in_a, in_b;
	logic [LW-1:0]      lvl_dec, lvl_inc;
	logic [DEPTH_W-1:0] diff_sh;
	logic [DEPTH_W-1:0] dep_next;

	assign alu_res  = alu_x + (alu_sub ? ~alu_y : alu_y) + ALU_W'(alu_sub);
	assign alu_neg  = alu_res[ALU_W-1];
	assign in_a     = to_idx(req.node_a);
	assign in_b     = to_idx(req.node_b);
	assign lvl_dec  = lvl_q - LW'(1);
	assign lvl_inc  = lvl_q + LW'(1);
	assign diff_sh  = diff_q >> lvl_q;
	assign dep_next = alu_res[DEPTH_W] ? DEPTH_MAX : alu_res[DEPTH_W-1:0];

	assign req.ready           = (state_q == S_IDLE);
	assign rsp.valid           = rsp_valid_q;
	assign rsp.common_ancestor = rsp_anc_q;
	assign rsp.distance        = rsp_dist_q;

	always_comb begin
		state_d     = state_q;
		lvl_d       = lvl_q;
		anc_we      = 1'b0;
		anc_waddr   = '0;
		anc_wdata   = '0;
		anc_raddr_a = '0;
		anc_raddr_b = '0;
		dep_we      = 1'b0;
		dep_waddr   = '0;
		dep_wdata   = '0;
		dep_raddr_a = '0;
		dep_raddr_b = '0;
		alu_x       = '0;
		alu_y       = '0;
		alu_sub     = 1'b0;
		rsp_load    = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				anc_we    = 1'b1;
				anc_waddr = clr_q;
				dep_we    = 1'b1;
				dep_waddr = clr_q[AW-1:LW];
				if (clr_q == CLR_LAST)
					state_d = S_IDLE;
			end
			S_IDLE: begin
				dep_raddr_a = (req.action == ACT_QUERY) ? in_a : in_b;
				dep_raddr_b = in_b;
				if (req.valid) begin
					if (req.action == ACT_QUERY)
						state_d = S_Q_DEP;
					else if (in_a != '0)
						state_d = S_AT_DEP;
				end
			end
			S_AT_DEP: begin
				// child in a_q, parent in b_q
				alu_x     = ext_depth(dep_rdata_a_q);
				alu_y     = ALU_W'(1);
				dep_we    = 1'b1;
				dep_waddr = a_q;
				dep_wdata = dep_next;
				anc_we    = 1'b1;
				anc_waddr = {a_q, {LW{1'b0}}};
				anc_wdata = b_q;
				lvl_d     = LW'(1);
				state_d   = S_AT_RD;
			end
			S_AT_RD: begin
				anc_raddr_a = {b_q, lvl_dec};
				state_d     = S_AT_WB;
			end
			S_AT_WB: begin
				anc_we    = 1'b1;
				anc_waddr = {a_q, lvl_q};
				anc_wdata = anc_rdata_a_q;
				if (lvl_q == LVL_TOP) begin
					state_d = S_IDLE;
				end else begin
					lvl_d   = lvl_inc;
					state_d = S_AT_RD;
				end
			end
			S_Q_DEP: begin
				alu_x   = ext_depth(dep_rdata_a_q);
				alu_y   = ext_depth(dep_rdata_b_q);
				alu_sub = 1'b1;
				state_d = S_Q_DIFF;
			end
			S_Q_DIFF: begin
				alu_x   = ext_depth(da_q);
				alu_y   = ext_depth(db_q);
				alu_sub = 1'b1;
				lvl_d   = LVL_TOP;
				state_d = S_LIFT;
			end
			S_LIFT: begin
				if (diff_sh[0]) begin
					anc_raddr_a = {a_q, lvl_q};
					state_d     = S_LIFT_WB;
				end else if (lvl_q == '0) begin
					state_d = S_CHECK;
				end else begin
					lvl_d = lvl_dec;
				end
			end
			S_LIFT_WB: begin
				if (lvl_q == '0) begin
					state_d = S_CHECK;
				end else begin
					lvl_d   = lvl_dec;
					state_d = S_LIFT;
				end
			end
			S_CHECK: begin
				alu_x = ext_depth(da_q);
				alu_y = ext_depth(db_q);
				if (a_q == b_q) begin
					state_d = S_TOP_RD;
				end else begin
					lvl_d   = LVL_TOP;
					state_d = S_JUMP;
				end
			end
			S_JUMP: begin
				anc_raddr_a = {a_q, lvl_q};
				anc_raddr_b = {b_q, lvl_q};
				state_d     = S_JUMP_WB;
			end
			S_JUMP_WB: begin
				if (lvl_q == '0) begin
					state_d = S_PARENT;
				end else begin
					lvl_d   = lvl_dec;
					state_d = S_JUMP;
				end
			end
			S_PARENT: begin
				anc_raddr_a = {a_q, {LW{1'b0}}};
				state_d     = S_PARENT_WB;
			end
			S_PARENT_WB: begin
				dep_raddr_a = anc_rdata_a_q;
				state_d     = S_TOP_WB;
			end
			S_TOP_RD: begin
				dep_raddr_a = a_q;
				state_d     = S_TOP_WB;
			end
			S_TOP_WB: begin
				state_d = S_DIST;
			end
			S_DIST: begin
				alu_x   = {{(ALU_W - DIST_W){1'b0}}, sum_q};
				alu_y   = {{(ALU_W - DEPTH_W - 1){1'b0}}, dt_q, 1'b0};
				alu_sub = 1'b1;
				if (!rsp_valid_q || rsp.ready) begin
					rsp_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			lvl_q       <= '0;
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			lvl_q   <= lvl_d;
			if (state_q == S_CLEAR)
				clr_q <= clr_q + AW'(1);
			if (rsp_load)
				rsp_valid_q <= 1'b1;
			else if (rsp.ready)
				rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					a_q <= in_a;
					b_q <= in_b;
				end
			end
			S_AT_WB: begin
				b_q <= anc_rdata_a_q;
			end
			S_Q_DEP: begin
				// keep the deeper node in a
				if (alu_neg) begin
					a_q  <= b_q;
					b_q  <= a_q;
					da_q <= dep_rdata_b_q;
					db_q <= dep_rdata_a_q;
				end else begin
					da_q <= dep_rdata_a_q;
					db_q <= dep_rdata_b_q;
				end
			end
			S_Q_DIFF: begin
				diff_q <= alu_res[DEPTH_W-1:0];
			end
			S_LIFT_WB: begin
				a_q <= anc_rdata_a_q;
			end
			S_CHECK: begin
				sum_q <= alu_res[DIST_W-1:0];
				top_q <= a_q;
			end
			S_JUMP_WB: begin
				if (anc_rdata_a_q != anc_rdata_b_q) begin
					a_q <= anc_rdata_a_q;
					b_q <= anc_rdata_b_q;
				end
			end
			S_PARENT_WB: begin
				top_q <= anc_rdata_a_q;
			end
			S_TOP_WB: begin
				dt_q <= dep_rdata_a_q;
			end
			S_DIST: begin
				if (rsp_load) begin
					rsp_anc_q  <= to_field(top_q);
					rsp_dist_q <= alu_neg ? '0 : alu_res[DIST_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (anc_we)
			anc_mem[anc_waddr] <= anc_wdata;
		anc_rdata_a_q <= anc_mem[anc_raddr_a];
		anc_rdata_b_q <= anc_mem[anc_raddr_b];
	end

	always_ff @(posedge clk) begin
		if (dep_we)
			dep_mem[dep_waddr] <= dep_wdata;
		dep_rdata_a_q <= dep_mem[dep_raddr_a];
		dep_rdata_b_q <= dep_mem[dep_raddr_b];
	end

endmodule

[rtl/core/tld_checker.sv]
// Port-level checks of the tree LCA / distance engine, bound to its top level.
`timescale 1ns / 1ps
module tld_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             req_valid,
	input logic                             req_ready,
	input logic                             req_action,
	input logic                             rsp_valid,
	input logic                             rsp_ready,
	input logic [tld_pkg::NODE_FIELD_W-1:0] rsp_common_ancestor,
	input logic [tld_pkg::DIST_W-1:0]       rsp_distance
);
	import tld_pkg::*;

	// an accepted query drops ready in the cycle after its accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready && req_action == ACT_QUERY) |=> !req_ready)
		else $error("ready stayed high right after a query item was accepted");

	// an attach never produces a result
	a_attach_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready && req_action == ACT_ATTACH && !rsp_valid) |=> !rsp_valid)
		else $error("result appeared after an attach item");

	// a new result shows only once the sequencer is back to idle
	a_result_at_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> req_ready)
		else $error("result raised while the engine is still busy");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=>
			(rsp_valid && $stable(rsp_common_ancestor) && $stable(rsp_distance)))
		else $error("stalled result changed or dropped");

endmodule

bind tree_lca_distance_engine tld_checker u_tld_checker (
	.clk                 (clk),
	.arst_n              (arst_n),
	.req_valid           (req.valid),
	.req_ready           (req.ready),
	.req_action          (req.action),
	.rsp_valid           (rsp.valid),
	.rsp_ready           (rsp.ready),
	.rsp_common_ancestor (rsp.common_ancestor),
	.rsp_distance        (rsp.distance)
);

[sim/lca_checker.sv]
// Checker for the tree LCA engine: mirrors the depth store and lifting table, scores every response.
`timescale 1ns / 1ps
module lca_checker #(
	parameter int unsigned NODE_COUNT = tld_pkg::DEF_NODE_COUNT,
	parameter int unsigned LEVELS     = tld_pkg::DEF_LEVELS
) (
	input  logic        clk,
	input  logic        arst_n,
	tld_req_if          req,
	tld_rsp_if          rsp,
	output int unsigned mismatches,
	output int unsigned pending
);
	import tld_pkg::*;

	typedef logic [NODE_FIELD_W-1:0] node_t;
	typedef logic [DEPTH_W-1:0]      depth_t;

	typedef struct packed {
		node_t             anc;
		logic [DIST_W-1:0] span;
	} lca_result_t;

	depth_t      depth_of [NODE_COUNT];
	node_t       jump_up  [NODE_COUNT][LEVELS];
	lca_result_t lca_expected_q[$];

	function automatic node_t wrap_node(input node_t field);
		return node_t'(int'(field) % NODE_COUNT);
	endfunction

	function automatic void graft_node(input node_t child, input node_t parent);
		int unsigned d;
		node_t       mid;
		// the sentinel never moves
		if (child == '0)
			return;
		d = depth_of[parent] + 1;
		if (d > DEPTH_MAX)
			d = DEPTH_MAX;
		depth_of[child]   = depth_t'(d);
		jump_up[child][0] = parent;
		for (int j = 1; j < LEVELS; j++) begin
			mid = jump_up[child][j-1];
			jump_up[child][j] = jump_up[mid][j-1];
		end
	endfunction

	function automatic node_t common_ancestor_of(input node_t a, input node_t b);
		node_t       x;
		node_t       y;
		node_t       t;
		node_t       px;
		node_t       py;
		int unsigned diff;
		x = a;
		y = b;
		if (x == y)
			return x;
		if (depth_of[x] < depth_of[y]) begin
			t = x;
			x = y;
			y = t;
		end
		diff = depth_of[x] - depth_of[y];
		for (int i = LEVELS - 1; i >= 0; i--) begin
			if (i < 32 && ((diff >> i) & 1))
				x = jump_up[x][i];
		end
		if (x == y)
			return x;
		for (int i = LEVELS - 1; i >= 0; i--) begin
			px = jump_up[x][i];
			py = jump_up[y][i];
			if (px != py) begin
				x = px;
				y = py;
			end
		end
		return jump_up[x][0];
	endfunction

	function automatic lca_result_t predict_query(input node_t a, input node_t b);
		lca_result_t r;
		node_t       top;
		int          hops;
		top  = common_ancestor_of(a, b);
		hops = int'(depth_of[a]) + int'(depth_of[b]) - 2 * int'(depth_of[top]);
		// broken trees can put the ancestor below both nodes
		if (hops < 0)
			hops = 0;
		r.anc  = top;
		r.span = DIST_W'(hops);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : score
		lca_result_t got;
		lca_result_t want;
		node_t       a;
		node_t       b;
		if (!arst_n) begin
			for (int v = 0; v < NODE_COUNT; v++) begin
				depth_of[v] = '0;
				for (int j = 0; j < LEVELS; j++)
					jump_up[v][j] = '0;
			end
			lca_expected_q.delete();
			mismatches = 0;
			pending    = 0;
		end else begin
			// responses first: one accepted in this edge belongs to an older query
			if (rsp.valid && rsp.ready) begin
				got.anc  = rsp.common_ancestor;
				got.span = rsp.distance;
				if (lca_expected_q.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: unexpected result: ancestor %0d distance %0d",
							$time, got.anc, got.span);
					mismatches++;
				end else begin
					want = lca_expected_q.pop_front();
					if (got.anc !== want.anc || got.span !== want.span) begin
						if (mismatches < 10)
							$display("%0t: expected anc %0d dist %0d, got anc %0d dist %0d",
								$time, want.anc, want.span, got.anc, got.span);
						mismatches++;
					end
				end
			end
			if (req.valid && req.ready) begin
				a = wrap_node(req.node_a);
				b = wrap_node(req.node_b);
				if (req.action == ACT_QUERY)
					lca_expected_q.insert(lca_expected_q.size(), predict_query(a, b));
				else
					graft_node(a, b);
			end
			pending = lca_expected_q.size();
		end
	end

endmodule

[sim/testbench.sv]
// Top of the tree LCA engine testbench: clock, reset, tree and query stimulus, verdict.
`timescale 1ns / 1ps
module testbench;
	import tld_pkg::*;

	typedef logic [NODE_FIELD_W-1:0] node_t;

	// clearing pass, ~600 items at worst-case query latency and stalls, several times over
	localparam int unsigned CYCLE_LIMIT = 600_000;

	logic        clk;
	logic        arst_n;
	logic        req_taken = 1'b0;
	int unsigned mismatches;
	int unsigned pending;
	int unsigned cycle_count = 0;
	int unsigned gap_pct     = 0;
	int unsigned stall_pct   = 0;
	int unsigned stall_left  = 0;
	bit          calm        = 1'b0;

	tld_req_if req();
	tld_rsp_if rsp();

	tree_lca_distance_engine u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	lca_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.rsp        (rsp),
		.mismatches (mismatches),
		.pending    (pending)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk)
		req_taken <= req.valid && req.ready;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// response back-pressure in bursts
	always @(negedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			rsp.ready  <= 1'b0;
		end else if (!calm && stall_pct != 0 && $urandom_range(99, 0) < stall_pct) begin
			stall_left <= $urandom_range(9, 0);
			rsp.ready  <= 1'b0;
		end else begin
			rsp.ready <= 1'b1;
		end
	end

	function automatic int unsigned idle_level();
		case ($urandom_range(3, 0))
			0: return 0;
			1: return 10;
			2: return 30;
			default: return 60;
		endcase
	endfunction

	task automatic send_item(input logic act, input node_t a, input node_t b);
		if (!calm && gap_pct != 0 && $urandom_range(99, 0) < gap_pct) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(10, 1)) @(negedge clk);
		end
		req.valid  <= 1'b1;
		req.action <= act;
		req.node_a <= a;
		req.node_b <= b;
		do @(negedge clk); while (!req_taken);
	endtask

	task automatic drain(input int unsigned settle);
		req.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (settle) @(negedge clk);
	endtask

	// one random tree per round, queries over it, some noise in between
	task automatic grow_and_query(input int unsigned quota);
		node_t       members[$];
		node_t       perm[1023];
		node_t       k;
		node_t       parent;
		int unsigned sent;
		int unsigned size;
		int unsigned pick;
		sent = 0;
		for (int i = 0; i < 1023; i++)
			perm[i] = node_t'(i + 1);
		while (sent < quota) begin
			gap_pct   = idle_level();
			stall_pct = idle_level();
			for (int i = 1022; i > 0; i--) begin
				pick       = $urandom_range(i, 0);
				k          = perm[i];
				perm[i]    = perm[pick];
				perm[pick] = k;
			end
			size = $urandom_range(40, 3);
			members.delete();
			for (int i = 0; i < size; i++) begin
				if (i == 0)
					parent = '0;
				else if ($urandom_range(1, 0))
					parent = members[members.size() - 1];
				else
					parent = members[$urandom_range(members.size() - 1, 0)];
				send_item(ACT_ATTACH, perm[i], parent);
				members.insert(members.size(), perm[i]);
				sent++;
			end
			repeat ($urandom_range(2 * size, size / 2 + 1)) begin
				case ($urandom_range(11, 0))
					0: send_item(1'($urandom_range(1, 0)), node_t'($urandom), node_t'($urandom));
					1: send_item(ACT_ATTACH, '0, node_t'($urandom));
					2: send_item(ACT_QUERY, members[$urandom_range(members.size() - 1, 0)],
						node_t'($urandom));
					3: begin
						k = members[$urandom_range(members.size() - 1, 0)];
						send_item(ACT_QUERY, k, k);
					end
					4: send_item(ACT_QUERY, '0, members[$urandom_range(members.size() - 1, 0)]);
					default: send_item(ACT_QUERY, members[$urandom_range(members.size() - 1, 0)],
						members[$urandom_range(members.size() - 1, 0)]);
				endcase
				sent++;
			end
		end
	endtask

	initial begin
		arst_n     = 1'b0;
		req.valid  = 1'b0;
		req.action = ACT_ATTACH;
		req.node_a = '0;
		req.node_b = '0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		// directed: empty store, extremes, sentinel, broken trees
		send_item(ACT_QUERY, '0, '0);
		send_item(ACT_ATTACH, 10'd1023, '0);
		send_item(ACT_ATTACH, '0, 10'd1023);
		send_item(ACT_ATTACH, 10'd1, 10'd1023);
		send_item(ACT_ATTACH, 10'd2, 10'd1);
		send_item(ACT_ATTACH, 10'd3, 10'd1);
		send_item(ACT_QUERY, 10'd2, 10'd3);
		send_item(ACT_QUERY, 10'd2, 10'd1023);
		send_item(ACT_QUERY, 10'd3, 10'd3);
		send_item(ACT_QUERY, '0, 10'd2);
		send_item(ACT_QUERY, 10'd500, 10'd2);
		send_item(ACT_ATTACH, 10'd7, '0);
		send_item(ACT_ATTACH, 10'd8, 10'd7);
		send_item(ACT_ATTACH, 10'd9, 10'd7);
		// re-attach under its own child: ancestor ends up deeper than both, distance clamps
		send_item(ACT_ATTACH, 10'd7, 10'd8);
		send_item(ACT_QUERY, 10'd8, 10'd9);
		send_item(ACT_ATTACH, 10'd11, 10'd10);
		send_item(ACT_QUERY, 10'd11, 10'd1023);
		send_item(ACT_QUERY, 10'd1023, '0);
		drain(0);

		// one long chain: wide depth gaps use the upper lifting levels
		gap_pct   = 10;
		stall_pct = 30;
		for (int i = 1; i < 301; i++)
			send_item(ACT_ATTACH, node_t'(i), node_t'(i - 1));
		send_item(ACT_QUERY, 10'd1, 10'd299);
		send_item(ACT_QUERY, '0, 10'd299);
		send_item(ACT_QUERY, 10'd300, 10'd150);
		repeat (30)
			send_item(ACT_QUERY, node_t'($urandom_range(299, 1)), node_t'($urandom_range(299, 1)));
		// node hung under itself: every ancestor level points back at the node
		send_item(ACT_ATTACH, 10'd300, 10'd300);
		send_item(ACT_ATTACH, 10'd299, 10'd300);
		send_item(ACT_QUERY, 10'd299, 10'd300);
		send_item(ACT_QUERY, 10'd300, 10'd5);
		send_item(ACT_QUERY, 10'd299, 10'd200);

		grow_and_query(60);
		drain(0);
		grow_and_query(60);
		calm = 1'b1;
		grow_and_query(40);
		drain(60);

		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

[filelist.f]
rtl/core/tld_pkg.sv
rtl/core/tld_ifs.sv
rtl/core/tree_lca_distance_engine.sv
rtl/core/tld_checker.sv
sim/lca_checker.sv
sim/testbench.sv
